// ===== rtl/ats_pkg.sv =====
// Shared types and constants for the ASCII token splitter.
package ats_pkg;

  localparam int unsigned OFFSET_BITS = 31;
  localparam int unsigned MAP_BITS    = 64;
  localparam int unsigned CFG_IDX_W   = 2;

  // Result queue geometry
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_HIGH = CFG_IDX_W'(1);

  // Reset maps: digits in the low half, letters in the high half
  localparam logic [MAP_BITS-1:0] TOKEN_LOW_RST  = 64'h03FF_0000_0000_0000;
  localparam logic [MAP_BITS-1:0] TOKEN_HIGH_RST = 64'h07FF_FFFE_07FF_FFFE;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DELTA   = 8'd32;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  typedef struct packed {
    logic [7:0]             folded_byte;
    logic                   token_first;
    logic                   token_last;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [OFFSET_BITS-1:0] end_offset;
  } result_t;

  typedef struct packed {
    logic a_valid;  // held byte is emitted
    logic b_valid;  // incoming byte is emitted (token at end of text)
  } push_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      r = b + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

// ===== rtl/ats_token_core.sv =====
// Token state machine: classify a byte, emit held byte, update offsets.
module ats_token_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [7:0]                      byte_i,
  input  logic                            eot_i,
  input  logic [ats_pkg::MAP_BITS-1:0]    map_low_i,
  input  logic [ats_pkg::MAP_BITS-1:0]    map_high_i,
  output ats_pkg::push_t                  push_o,
  output ats_pkg::result_t                res_a_o,
  output ats_pkg::result_t                res_b_o
);

  logic [7:0]                        held_byte_q, held_byte_d;
  logic                              held_valid_q, held_valid_d;
  logic                              held_first_q, held_first_d;
  logic [ats_pkg::OFFSET_BITS-1:0]   tok_start_q, tok_start_d;
  logic [ats_pkg::OFFSET_BITS-1:0]   pos_q, pos_d;

  logic [2*ats_pkg::MAP_BITS-1:0]    token_map;
  logic                              is_tok;
  logic [ats_pkg::OFFSET_BITS-1:0]   pos_nxt;
  logic [ats_pkg::OFFSET_BITS-1:0]   start_eff;

  assign token_map = {map_high_i, map_low_i};
  assign is_tok    = byte_i[7] | token_map[byte_i[6:0]];
  assign pos_nxt   = (pos_q == ats_pkg::POS_MAX) ? ats_pkg::POS_MAX
                                                 : pos_q + ats_pkg::OFFSET_BITS'(1);
  assign start_eff = held_valid_q ? tok_start_q : pos_q;

  always_comb begin
    push_o.a_valid       = step_i & held_valid_q;
    push_o.b_valid       = step_i & is_tok & eot_i;

    // held byte: closes the token unless a token byte follows
    res_a_o.folded_byte  = ats_pkg::fold_case(held_byte_q);
    res_a_o.token_first  = held_first_q;
    res_a_o.token_last   = ~is_tok;
    res_a_o.start_offset = tok_start_q;
    res_a_o.end_offset   = is_tok ? '0 : pos_q;

    // incoming token byte at end of text
    res_b_o.folded_byte  = ats_pkg::fold_case(byte_i);
    res_b_o.token_first  = ~held_valid_q;
    res_b_o.token_last   = 1'b1;
    res_b_o.start_offset = start_eff;
    res_b_o.end_offset   = pos_nxt;

    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    held_first_d = held_first_q;
    tok_start_d  = tok_start_q;
    pos_d        = pos_q;
    if (step_i) begin
      if (is_tok) begin
        tok_start_d = start_eff;
        held_byte_d = byte_i;
      end
      held_valid_d = is_tok & ~eot_i;
      held_first_d = is_tok & ~eot_i & ~held_valid_q;
      pos_d        = eot_i ? '0 : pos_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      held_first_q <= 1'b0;
      tok_start_q  <= '0;
      pos_q        <= '0;
    end else begin
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      held_first_q <= held_first_d;
      tok_start_q  <= tok_start_d;
      pos_q        <= pos_d;
    end
  end

  a_eot_clears_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && eot_i |=> !held_valid_q && pos_q == '0)
    else $error("held byte or position survived end of text");

  a_first_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_first_q |-> held_valid_q)
    else $error("first marker without a held byte");

  a_pos_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !eot_i |=> pos_q >= $past(pos_q) && pos_q != '0)
    else $error("position went backwards without end of text");

endmodule

// ===== rtl/ats_result_fifo.sv =====
// Result queue: takes up to two results a cycle, gives one a cycle.
module ats_result_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ats_pkg::push_t                    push_i,
  input  ats_pkg::result_t                  res_a_i,
  input  ats_pkg::result_t                  res_b_i,
  input  logic                              pop_i,
  output logic                              head_valid_o,
  output ats_pkg::result_t                  head_o,
  output logic [ats_pkg::QUEUE_CNT_W-1:0]   count_o
);

  ats_pkg::result_t                  mem_q [ats_pkg::QUEUE_DEPTH];
  logic [ats_pkg::QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [ats_pkg::QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ats_pkg::QUEUE_CNT_W-1:0]   count_q, count_d;
  logic [ats_pkg::QUEUE_PTR_W-1:0]   wr_ptr_1;
  ats_pkg::result_t                  wr_data_0;
  logic                              wr_en_0, wr_en_1;
  logic                              do_pop;

  // Pack: first slot takes held byte if present, else the incoming byte
  assign wr_en_0   = push_i.a_valid | push_i.b_valid;
  assign wr_en_1   = push_i.a_valid & push_i.b_valid;
  assign wr_data_0 = push_i.a_valid ? res_a_i : res_b_i;
  assign wr_ptr_1  = wr_ptr_q + ats_pkg::QUEUE_PTR_W'(1);
  assign do_pop    = pop_i & (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q + ats_pkg::QUEUE_PTR_W'(wr_en_0) + ats_pkg::QUEUE_PTR_W'(wr_en_1);
    rd_ptr_d = rd_ptr_q + ats_pkg::QUEUE_PTR_W'(do_pop);
    count_d  = count_q + ats_pkg::QUEUE_CNT_W'(wr_en_0) + ats_pkg::QUEUE_CNT_W'(wr_en_1)
               - ats_pkg::QUEUE_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_0) begin
      mem_q[wr_ptr_q] <= wr_data_0;
    end
    if (wr_en_1) begin
      mem_q[wr_ptr_1] <= res_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign count_o      = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ats_pkg::QUEUE_CNT_W'(ats_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_ptr_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ats_pkg::QUEUE_PTR_W'(wr_ptr_q - rd_ptr_q) == ats_pkg::QUEUE_PTR_W'(count_q))
    else $error("queue pointers disagree with count");

  a_pair_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_1 |-> count_q <= ats_pkg::QUEUE_CNT_W'(ats_pkg::QUEUE_DEPTH - 2))
    else $error("two results pushed without two free slots");

endmodule

// ===== rtl/ascii_token_splitter.sv =====
// Top level of the ASCII token splitter: input stage, config map, core, result queue.
//
//  channel  direction  handshake                   payload
//  -------  ---------  --------------------------  --------------------------------------
//  in       sink       in_valid_i / in_ready_o     text_byte_i, end_of_text_i
//  out      source     out_valid_o / out_ready_i   folded_byte_o, token_first_o,
//                                                  token_last_o, start_offset_o,
//                                                  end_offset_o
//  cfg      sink       cfg_we_i (no wait)          cfg_index_i, cfg_data_i
//
// One item is accepted per cycle while in_ready_o is high. A result leaves once its item has
// passed the input register and the token core has written the result queue.
// An item that yields two results (token byte at end of text after a held byte)
// gives them out one at a time through the single read port of the result queue.
// in_ready_o drops only while the queue has fewer than two free slots.
// Reset clears the control state and loads the default map (digits and letters); no clearing pass.
module ascii_token_splitter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          text_byte_i,
  input  logic                                end_of_text_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [7:0]                          folded_byte_o,
  output logic                                token_first_o,
  output logic                                token_last_o,
  output logic [ats_pkg::OFFSET_BITS-1:0]     start_offset_o,
  output logic [ats_pkg::OFFSET_BITS-1:0]     end_offset_o,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [ats_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ats_pkg::MAP_BITS-1:0]        cfg_data_i
);

  // Token-character map, to be written only while idle; the block does not enforce this
  logic [ats_pkg::MAP_BITS-1:0] map_low_q, map_high_q;

  // Input register stage
  logic                         in_valid_q, in_valid_d;
  logic [7:0]                   in_byte_q;
  logic                         in_eot_q;
  logic                         advance;
  logic                         in_accept;

  ats_pkg::push_t               push;
  ats_pkg::result_t             res_a, res_b, head;
  logic [ats_pkg::QUEUE_CNT_W-1:0] q_count;
  logic                         head_valid;

  // Advance the held input only when the queue can absorb two results
  assign advance    = in_valid_q
                    & (q_count <= ats_pkg::QUEUE_CNT_W'(ats_pkg::QUEUE_DEPTH - 2));
  assign in_ready_o = ~in_valid_q | advance;
  assign in_accept  = in_valid_i & in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= text_byte_i;
      in_eot_q  <= end_of_text_i;
    end
  end

  // Config writes; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_low_q  <= ats_pkg::TOKEN_LOW_RST;
      map_high_q <= ats_pkg::TOKEN_HIGH_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == ats_pkg::CFG_TOKEN_LOW) begin
        map_low_q <= cfg_data_i;
      end
      if (cfg_index_i == ats_pkg::CFG_TOKEN_HIGH) begin
        map_high_q <= cfg_data_i;
      end
    end
  end

  ats_token_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (in_byte_q),
    .eot_i      (in_eot_q),
    .map_low_i  (map_low_q),
    .map_high_i (map_high_q),
    .push_o     (push),
    .res_a_o    (res_a),
    .res_b_o    (res_b)
  );

  ats_result_fifo u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .res_a_i      (res_a),
    .res_b_i      (res_b),
    .pop_i        (out_ready_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .count_o      (q_count)
  );

  assign out_valid_o    = head_valid;
  assign folded_byte_o  = head.folded_byte;
  assign token_first_o  = head.token_first;
  assign token_last_o   = head.token_last;
  assign start_offset_o = head.start_offset;
  assign end_offset_o   = head.end_offset;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> q_count <= ats_pkg::QUEUE_CNT_W'(ats_pkg::QUEUE_DEPTH - 2))
    else $error("core stepped without queue room");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q) && $stable(in_eot_q))
    else $error("stalled input stage lost its item");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.a_valid && push.b_valid |-> in_eot_q)
    else $error("two results outside end of text");

endmodule

// ===== verif/ascii_token_splitter_test.sv =====
// Self-checking testbench for the ASCII token splitter: directed, register and random traffic.
`timescale 1ns / 100ps

module ascii_token_splitter_test;

  // Register slots past the two map halves; writes to them must change nothing
  localparam logic [ats_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = ats_pkg::CFG_IDX_W'(2);
  localparam logic [ats_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = ats_pkg::CFG_IDX_W'(3);

  localparam int unsigned HALF_PERIOD   = 4;
  localparam int unsigned DRAIN_CYCLES  = 8;     // well past the pipeline depth
  localparam int unsigned IDLE_LIMIT    = 4000;  // cycles with no handshake at all
  localparam int unsigned HOLD_OFF_LEN  = 300;   // long receiver stall for back-pressure
  localparam int unsigned PHASE_ITEMS   = 165;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            in_valid_i     = 1'b0;
  logic                            in_ready_o;
  logic [7:0]                      text_byte_i    = '0;
  logic                            end_of_text_i  = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i    = 1'b0;
  logic [7:0]                      folded_byte_o;
  logic                            token_first_o;
  logic                            token_last_o;
  logic [ats_pkg::OFFSET_BITS-1:0] start_offset_o;
  logic [ats_pkg::OFFSET_BITS-1:0] end_offset_o;
  logic                            cfg_we_i       = 1'b0;
  logic [ats_pkg::CFG_IDX_W-1:0]   cfg_index_i    = '0;
  logic [ats_pkg::MAP_BITS-1:0]    cfg_data_i     = '0;

  // Shadow of the block: token map and splitter state
  logic [ats_pkg::MAP_BITS-1:0]    map_lo     = ats_pkg::TOKEN_LOW_RST;
  logic [ats_pkg::MAP_BITS-1:0]    map_hi     = ats_pkg::TOKEN_HIGH_RST;
  logic [7:0]                      held_chr   = '0;
  logic                            held_ok    = 1'b0;
  logic                            held_opens = 1'b0;
  logic [ats_pkg::OFFSET_BITS-1:0] tok_start  = '0;
  logic [ats_pkg::OFFSET_BITS-1:0] text_pos   = '0;

  // Token bytes predicted but not yet seen on the output, oldest first
  ats_pkg::result_t token_bytes_due[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned stall_left    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned errors        = 0;
  int unsigned items_sent    = 0;
  int unsigned bytes_seen    = 0;
  int unsigned map_writes    = 0;

  ascii_token_splitter u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .folded_byte_o  (folded_byte_o),
    .token_first_o  (token_first_o),
    .token_last_o   (token_last_o),
    .start_offset_o (start_offset_o),
    .end_offset_o   (end_offset_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Splitter prediction
  // ---------------------------------------------------------------------------

  // Bytes with the top bit set are always part of a token; the rest look up the map.
  function automatic logic is_token_chr(input logic [7:0] b);
    if (b[7]) return 1'b1;
    return b[6] ? map_hi[b[5:0]] : map_lo[b[5:0]];
  endfunction

  // Advance an offset, sticking at the all-ones value.
  function automatic logic [ats_pkg::OFFSET_BITS-1:0] step_pos(
    input logic [ats_pkg::OFFSET_BITS-1:0] p);
    return (p == ats_pkg::POS_MAX) ? p : p + ats_pkg::OFFSET_BITS'(1);
  endfunction

  function automatic void emit_token_byte(input logic [7:0] b, input logic first,
                                          input logic last,
                                          input logic [ats_pkg::OFFSET_BITS-1:0] stop);
    ats_pkg::result_t r;
    r.folded_byte  = (b >= ats_pkg::CHAR_UPPER_A && b <= ats_pkg::CHAR_UPPER_Z)
                     ? b + ats_pkg::CASE_DELTA : b;
    r.token_first  = first;
    r.token_last   = last;
    r.start_offset = tok_start;
    r.end_offset   = last ? stop : '0;
    token_bytes_due.push_back(r);
  endfunction

  // One text byte in: zero, one or two token bytes predicted out.
  function automatic void split_byte(input logic [7:0] b, input logic eot);
    logic [ats_pkg::OFFSET_BITS-1:0] pos;
    pos = text_pos;
    if (is_token_chr(b)) begin
      if (held_ok) begin
        // flush the held byte, the token goes on
        emit_token_byte(held_chr, held_opens, 1'b0, '0);
        held_opens = 1'b0;
      end else begin
        tok_start  = pos;
        held_opens = 1'b1;
      end
      held_chr = b;
      held_ok  = 1'b1;
      if (eot) begin
        // text ends inside a token: close it on this very byte
        emit_token_byte(held_chr, held_opens, 1'b1, step_pos(pos));
        held_ok    = 1'b0;
        held_opens = 1'b0;
      end
    end else if (held_ok) begin
      // separator closes the token; end offset is the separator's position
      emit_token_byte(held_chr, held_opens, 1'b1, pos);
      held_ok    = 1'b0;
      held_opens = 1'b0;
    end
    if (eot) begin
      held_ok    = 1'b0;
      held_opens = 1'b0;
      text_pos   = '0;
    end else begin
      text_pos = step_pos(pos);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one text byte, idling first at random; return at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    split_byte(b, eot);
    items_sent++;
  endtask

  // Drop valid, wait for every predicted token byte, then let the pipeline empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (token_bytes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_map(input logic [ats_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ats_pkg::MAP_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == ats_pkg::CFG_TOKEN_LOW) map_lo = data;
    else if (idx == ats_pkg::CFG_TOKEN_HIGH) map_hi = data;
    map_writes++;
  endtask

  // Text-like byte: mostly letters and digits, some punctuation, some anything.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return ats_pkg::CHAR_UPPER_A + 8'($urandom_range(25));
    if (r < 50) return "a" + 8'($urandom_range(25));
    if (r < 62) return "0" + 8'($urandom_range(9));
    if (r < 75) return 8'h20 + 8'($urandom_range(15));
    return 8'($urandom_range(255));
  endfunction

  task automatic load_random_maps();
    logic [ats_pkg::MAP_BITS-1:0] lo;
    logic [ats_pkg::MAP_BITS-1:0] hi;
    case ($urandom_range(4))
      0: begin
        lo = '1;
        hi = '1;
      end
      1: begin
        lo = '0;
        hi = '0;
      end
      2: begin
        lo = ats_pkg::TOKEN_LOW_RST;
        hi = ats_pkg::TOKEN_HIGH_RST;
      end
      3: begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end
      default: begin
        // sparse maps: short tokens, many separators
        lo = {$urandom, $urandom} & {$urandom, $urandom};
        hi = {$urandom, $urandom} & {$urandom, $urandom};
      end
    endcase
    write_map(ats_pkg::CFG_TOKEN_LOW, lo);
    write_map(ats_pkg::CFG_TOKEN_HIGH, hi);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // Random stalls, or a counted hold-off when one is requested.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  always @(posedge clk_i) begin : check_tokens
    ats_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      bytes_seen++;
      if (token_bytes_due.size() == 0) begin
        errors++;
        $display("%0t: token byte %0h with none expected", $time, folded_byte_o);
      end else begin
        want = token_bytes_due.pop_front();
        if (folded_byte_o !== want.folded_byte)
          report_field("folded_byte", 64'(want.folded_byte), 64'(folded_byte_o));
        if (token_first_o !== want.token_first)
          report_field("token_first", 64'(want.token_first), 64'(token_first_o));
        if (token_last_o !== want.token_last)
          report_field("token_last", 64'(want.token_last), 64'(token_last_o));
        if (start_offset_o !== want.start_offset)
          report_field("start_offset", 64'(want.start_offset), 64'(start_offset_o));
        if (end_offset_o !== want.end_offset)
          report_field("end_offset", 64'(want.end_offset), 64'(end_offset_o));
      end
    end
  end

  // Give up when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset map (digits and letters): every way a token opens and closes.
  task automatic test_default_map();
    send_idle_pct = 0;
    stall_pct     = 0;
    // plain word closed by a space
    send_byte("H", 1'b0);
    send_byte("i", 1'b0);
    send_byte(" ", 1'b0);
    // token running into end of text: held byte and last byte are queued together
    send_byte("0", 1'b0);
    send_byte("9", 1'b0);
    send_byte("Z", 1'b1);
    // one-byte text that is a whole token
    send_byte("Q", 1'b1);
    // separator at end of text closes the held byte
    send_byte("a", 1'b0);
    send_byte("-", 1'b1);
    // separator at end of text with nothing held
    send_byte("#", 1'b1);
    // top-half bytes are tokens, 0x00 and 0x7F are not
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h7F, 1'b1);
    // neighbors of the letter ranges stay separators
    send_byte("@", 1'b0);
    send_byte("[", 1'b0);
    send_byte(8'h60, 1'b0);
    send_byte(8'h7B, 1'b0);
    send_byte("z", 1'b1);
    settle();
  endtask

  // Both map halves at their extremes, and writes to the spare slots.
  task automatic test_map_registers();
    write_map(ats_pkg::CFG_TOKEN_LOW, '1);
    write_map(ats_pkg::CFG_TOKEN_HIGH, '1);
    // everything is a token; only A-Z fold
    send_byte("@", 1'b0);
    send_byte("A", 1'b0);
    send_byte("Z", 1'b0);
    send_byte("[", 1'b0);
    send_byte(8'h60, 1'b0);
    send_byte("a", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(" ", 1'b1);
    settle();
    write_map(ats_pkg::CFG_TOKEN_LOW, '0);
    write_map(ats_pkg::CFG_TOKEN_HIGH, '0);
    send_byte("A", 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte("5", 1'b0);
    send_byte(8'hC3, 1'b1);
    settle();
    // spare slots: the empty map must survive these
    write_map(CFG_SPARE_A, '1);
    write_map(CFG_SPARE_B, '1);
    send_byte("A", 1'b0);
    send_byte("b", 1'b0);
    send_byte(8'h90, 1'b1);
    settle();
    write_map(ats_pkg::CFG_TOKEN_LOW, ats_pkg::TOKEN_LOW_RST);
    write_map(ats_pkg::CFG_TOKEN_HIGH, ats_pkg::TOKEN_HIGH_RST);
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering
  // bytes: the result queue fills and the input must stall, then recover.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    stall_left    = HOLD_OFF_LEN;
    for (int i = 0; i < 48; i++) begin
      if (i % 7 == 6) send_byte(" ", i == 47);
      else send_byte(ats_pkg::CHAR_UPPER_A + 8'($urandom_range(25)), i == 47);
    end
    settle();
  endtask

  // Random texts under random maps, one phase per idling pattern.
  task automatic test_random_traffic();
    int unsigned idle_set[4]  = '{0, 80, 0, 15};
    int unsigned stall_set[4] = '{0, 0, 80, 15};
    int unsigned sent;
    int unsigned len;
    for (int p = 0; p < 4; p++) begin
      settle();
      load_random_maps();
      send_idle_pct = idle_set[p];
      stall_pct     = stall_set[p];
      sent          = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          // stray byte, end-of-text flag at random
          send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
          sent++;
        end else begin
          len = $urandom_range(1, 24);
          for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
          sent += len;
        end
      end
    end
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_map();
    test_map_registers();
    test_backpressure();
    test_random_traffic();

    settle();
    if (token_bytes_due.size() != 0) begin
      errors += token_bytes_due.size();
      $display("%0t: %0d token bytes never arrived", $time, token_bytes_due.size());
    end
    $display("Run: %0d text bytes in, %0d token bytes out, %0d map writes.",
             items_sent, bytes_seen, map_writes);
    $display("Covered default, full, empty and random maps under four stall patterns.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
